### hw/rtl/gdau_pkg.sv
// Shared types and constants for the Gregorian date arithmetic unit.
package gdau_pkg;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_SUB   = 3'd1;
  localparam logic [2:0] CMD_WDAY  = 3'd2;
  localparam logic [2:0] CMD_DAYS  = 3'd3;
  localparam logic [2:0] CMD_MONS  = 3'd4;
  localparam logic [2:0] CMD_YEARS = 3'd5;

  localparam int SW = 23;  // serial day number width
  localparam logic [SW-1:0] SER_LO   = 23'd146403;   // 0001-01-01
  localparam logic [SW-1:0] SER_HI   = 23'd3798461;  // 9999-12-31
  localparam logic [21:0]   DIFF_MAX = 22'd3652058;

  // Datapath operation selects.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SER_A, OP_SER_B, OP_TARGET,
    OP_ERA, OP_YOE, OP_DOY, OP_MP, OP_DATE, OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  // Cumulative days before shifted month mp (March = 0).
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0: r = 9'd0;    4'd1: r = 9'd31;   4'd2: r = 9'd61;
      4'd3: r = 9'd92;   4'd4: r = 9'd122;  4'd5: r = 9'd153;
      4'd6: r = 9'd184;  4'd7: r = 9'd214;  4'd8: r = 9'd245;
      4'd9: r = 9'd275;  4'd10: r = 9'd306; 4'd11: r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Days before year yy (shifted), yy below 16784.
  function automatic logic [SW-1:0] year_days(input logic [14:0] yy);
    logic [7:0] c;
    logic [SW-1:0] r;
    c = 8'((28'(yy) * 28'd5243) >> 19);  // yy/100
    r = SW'(yy) * 23'd365 + SW'(yy >> 2) - SW'(c) + SW'(c >> 2);
    return r;
  endfunction

endpackage

### hw/rtl/gdau_datapath.sv
// Datapath: date/serial conversion, differences and result assembly.
module gdau_datapath import gdau_pkg::*; (
  input  logic        clk_i,
  input  dp_cmd_t     cmd_i,
  input  logic [64:0] item_i,
  output logic        is_conv_o,
  output logic [51:0] res_o
);

  logic [2:0]    cmd_q;
  logic [4:0]    da_q, db_q;
  logic [3:0]    ma_q, mb_q;
  logic [13:0]   ya_q, yb_q;
  logic [15:0]   cnt_q;
  logic [SW-1:0] sa_q, sb_q, t_q, doe_q;
  logic [4:0]    era_q;
  logic [8:0]    yoe_q, doy_q;
  logic [3:0]    mp_q;
  logic          oor_q;
  logic [4:0]    dout_q;
  logic [3:0]    mout_q;
  logic [13:0]   yout_q;
  logic [51:0]   res_q;

  // serial of current date operand
  logic          sel_b;
  logic [4:0]    sd;
  logic [3:0]    sm_raw, smc, smp;
  logic [13:0]   sy;
  logic [14:0]   syy;
  logic [SW-1:0] ser;
  always_comb begin
    sel_b  = (cmd_i.op == OP_SER_B);
    sd     = sel_b ? db_q : da_q;
    sm_raw = sel_b ? mb_q : ma_q;
    sy     = sel_b ? yb_q : ya_q;
    smc    = (sm_raw == 4'd0) ? 4'd1 : ((sm_raw > 4'd12) ? 4'd12 : sm_raw);
    syy    = 15'(sy) + 15'd400 - ((smc <= 4'd2) ? 15'd1 : 15'd0);
    smp    = (smc > 4'd2) ? smc - 4'd3 : smc + 4'd9;
    ser    = year_days(syy) + SW'(month_start(smp)) + SW'(sd) - SW'(1);
  end

  // conversion back: helper signals
  logic [SW-1:0] tgt;
  logic          tgt_lo, tgt_hi;
  logic [SW-1:0] yoe_num;
  logic [8:0]    yoe_v;
  logic [SW-1:0] yoe_days;
  logic [12:0]   doy5;
  logic [3:0]    mp_v;
  logic [13:0]   yr;
  always_comb begin
    tgt = (cmd_q == CMD_ADD) ? sa_q + SW'(cnt_q)
        : ((sa_q >= SW'(cnt_q)) ? sa_q - SW'(cnt_q) : '0);
    tgt_lo = tgt < SER_LO;
    tgt_hi = tgt > SER_HI;
    // (doe - doe/1460 + doe/36524 - doe/146096)/365, doe < 146097
    yoe_num = doe_q - SW'((42'(doe_q) * 42'd5883517) >> 33)
            + SW'((42'(doe_q) * 42'd940745) >> 35)
            - SW'(doe_q == 23'd146096);
    yoe_v = 9'((42'(yoe_num) * 42'd367720) >> 27);
    yoe_days = SW'(yoe_q) * 23'd365 + SW'(yoe_q >> 2)
             - SW'((18'(yoe_q) * 18'd41) >> 12);  // yoe/100
    doy5 = 13'(doy_q) * 13'd5 + 13'd2;
    mp_v = 4'((26'(doy5) * 26'd3427) >> 19);  // /153
    yr = 14'(era_q) * 14'd400 + 14'(yoe_q) + ((mp_q >= 4'd10) ? 14'd1 : 14'd0)
       - 14'd400;
  end

  // differences and flags
  logic [SW-1:0] sdiff;
  logic [17:0]   mna, mnb, mdiff;
  logic [13:0]   ydiff;
  logic [3:0]    mac, mbc;
  logic [21:0]   diff;
  logic [1:0]    ord;
  logic          leap;
  logic [2:0]    wday;
  logic [SW-1:0] w2;
  logic [7:0]    cent;
  always_comb begin
    sdiff = (sa_q >= sb_q) ? sa_q - sb_q : sb_q - sa_q;
    mac   = (ma_q == 4'd0) ? 4'd1 : ((ma_q > 4'd12) ? 4'd12 : ma_q);
    mbc   = (mb_q == 4'd0) ? 4'd1 : ((mb_q > 4'd12) ? 4'd12 : mb_q);
    mna   = 18'(ya_q) * 18'd12 + 18'(mac);
    mnb   = 18'(yb_q) * 18'd12 + 18'(mbc);
    mdiff = (mna >= mnb) ? mna - mnb : mnb - mna;
    ydiff = (ya_q >= yb_q) ? ya_q - yb_q : yb_q - ya_q;
    case (cmd_q)
      CMD_DAYS:  diff = (sdiff > SW'(DIFF_MAX)) ? DIFF_MAX : 22'(sdiff);
      CMD_MONS:  diff = 22'(mdiff);
      CMD_YEARS: diff = 22'(ydiff);
      default:   diff = '0;
    endcase
    if (ya_q != yb_q)      ord = (ya_q < yb_q) ? 2'd0 : 2'd2;
    else if (ma_q != mb_q) ord = (ma_q < mb_q) ? 2'd0 : 2'd2;
    else if (da_q != db_q) ord = (da_q < db_q) ? 2'd0 : 2'd2;
    else                   ord = 2'd1;
    cent = 8'((27'(ya_q) * 27'd5243) >> 19);
    leap = ((ya_q[1:0] == 2'b00) && (14'(cent) * 14'd100 != ya_q))
         || ((ya_q[1:0] == 2'b00) && (cent[1:0] == 2'b00) && (14'(cent) * 14'd100 == ya_q));
    w2   = sa_q + SW'(2);
    wday = 3'(w2 - SW'((64'(w2) * 64'd1227133514) >> 33) * SW'(7)) + 3'd1;
  end

  assign is_conv_o = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        {cnt_q, yb_q, mb_q, db_q, ya_q, ma_q, da_q, cmd_q} <= item_i;
        dout_q <= item_i[7:3];
        mout_q <= item_i[11:8];
        yout_q <= item_i[25:12];
        oor_q  <= 1'b0;
      end
      OP_SER_A: sa_q <= ser;
      OP_SER_B: sb_q <= ser;
      OP_TARGET: begin
        t_q   <= tgt_lo ? SER_LO : (tgt_hi ? SER_HI : tgt);
        oor_q <= tgt_lo | tgt_hi;
      end
      OP_ERA: begin
        era_q <= 5'((46'(t_q) * 46'd7525902) >> 40);  // /146097
      end
      OP_YOE: begin
        doe_q <= t_q - SW'(era_q) * 23'd146097;
      end
      OP_DOY: yoe_q <= yoe_v;
      OP_MP:  doy_q <= 9'(doe_q - yoe_days);
      OP_DATE: mp_q <= mp_v;
      OP_FINISH: begin
        dout_q <= 5'(doy_q - month_start(mp_q) + 9'd1);
        mout_q <= (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
        yout_q <= yr;
      end
      default: ;
    endcase
    res_q <= {oor_q, diff, ord, leap, wday, yout_q, mout_q, dout_q};
  end

  assign res_o = res_q;

endmodule

### hw/rtl/gdau_ctrl.sv
// Controller state machine sequencing the datapath steps.
module gdau_ctrl import gdau_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  logic    is_conv_i,
  output dp_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0, S_SA = 4'd1, S_SB = 4'd2, S_TGT = 4'd3,
    S_ERA = 4'd4, S_DOE = 4'd5, S_YOE = 4'd6, S_DOY = 4'd7, S_MP = 4'd8,
    S_FIN = 4'd9, S_RES = 4'd10, S_OUT = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE: if (in_valid_i) begin cmd_o.op = OP_LOAD; state_d = S_SA; end
      S_SA:  begin cmd_o.op = OP_SER_A; state_d = S_SB; end
      S_SB:  begin cmd_o.op = OP_SER_B; state_d = is_conv_i ? S_TGT : S_RES; end
      S_TGT: begin cmd_o.op = OP_TARGET; state_d = S_ERA; end
      S_ERA: begin cmd_o.op = OP_ERA; state_d = S_DOE; end
      S_DOE: begin cmd_o.op = OP_YOE; state_d = S_YOE; end
      S_YOE: begin cmd_o.op = OP_DOY; state_d = S_DOY; end
      S_DOY: begin cmd_o.op = OP_MP; state_d = S_MP; end
      S_MP:  begin cmd_o.op = OP_DATE; state_d = S_FIN; end
      S_FIN: begin cmd_o.op = OP_FINISH; state_d = S_RES; end
      S_RES: state_d = S_OUT;
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

### hw/rtl/gregorian_date_arithmetic_unit.sv
// Weekday and difference commands pass through the serial-A, serial-B and
// result states before the output state; add and subtract also pass through
// the target, era, day-of-era, year-of-era, day-of-year, month and finish
// states (serial-to-date steps). One transaction at a time: a new one is accepted after the result is taken.
// Reset: rst_ni asynchronous active low returns the controller to idle.
// The datapath holds no control state.
module gregorian_date_arithmetic_unit import gdau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd, day_a, month_a, year_a, day_b, month_b, year_b, day_count
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // day_out, month_out, year_out, weekday, leap_a, order, difference, out_of_range
  output logic [55:0] m_axis_tdata
);

  dp_cmd_t     cmd;
  logic [51:0] res;
  logic        is_conv;

  gdau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .is_conv_i  (is_conv),
    .cmd_o      (cmd)
  );

  gdau_datapath u_dp (
    .clk_i,
    .cmd_i    (cmd),
    .item_i   (s_axis_tdata[64:0]),
    .is_conv_o(is_conv),
    .res_o    (res)
  );

  assign m_axis_tdata = {4'b0, res};

endmodule
